// ===== rtl/core/qstg_pkg.sv =====
package qstg_pkg;

  localparam int AXES           = 7;
  localparam int MAX_SEGMENTS   = 16;
  localparam int NPOW           = 6;
  localparam int TIME_FRAC_BITS = 20;
  localparam int AXIS_W         = 3;
  localparam int SEG_W          = 4;
  localparam int POW_W          = 3;
  localparam int CNT_W          = 5;
  localparam int DATA_W         = 48;
  localparam int TIME_W         = 32;
  localparam int ID_W           = 32;
  localparam int COEF_DEPTH     = MAX_SEGMENTS * AXES * NPOW;
  localparam int COEF_AW        = $clog2(COEF_DEPTH);

  localparam logic [2:0] OP_LOAD_COEF = 3'd0;
  localparam logic [2:0] OP_LOAD_DUR  = 3'd1;
  localparam logic [2:0] OP_START     = 3'd2;
  localparam logic [2:0] OP_TICK      = 3'd3;
  localparam logic [2:0] OP_QUERY     = 3'd4;

  localparam logic [1:0] ST_ACTIVE = 2'd0;
  localparam logic [1:0] ST_DONE   = 2'd1;
  localparam logic [1:0] ST_NONE   = 2'd2;

  localparam logic signed [DATA_W-1:0] MAX48 = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] MIN48 = {1'b1, {(DATA_W-1){1'b0}}};

  typedef struct packed {
    logic [AXIS_W-1:0] axis;
    logic signed [DATA_W-1:0] pos;
    logic signed [DATA_W-1:0] vel;
    logic signed [DATA_W-1:0] acc;
    logic [SEG_W-1:0] seg;
    logic [ID_W-1:0] id;
    logic [1:0] status;
    logic last;
  } result_t;

  // Saturate a 52-bit signed value to 48 bits.
  function automatic logic signed [DATA_W-1:0] sat52(input logic signed [51:0] v);
    if (v > 52'sd140737488355327) return MAX48;
    if (v < -52'sd140737488355328) return MIN48;
    return v[DATA_W-1:0];
  endfunction

endpackage

// ===== rtl/core/quintic_spline_trajectory_gen.sv =====
// Quintic spline trajectory generator.
// Input stream (in_*): load coefficient, load duration, start, tick, query.
// Loads give no result. Start and query give one transfer on out_*,
// a tick gives seven, one per axis, with tlast on the final one.
// Axis, position, velocity, acceleration, segment and id are packed in
// out_tdata; the status travels in out_tuser.
// One item is handled at a time; in_tready is high only when idle.
// Loads leave the block idle. Start/query: the result is valid in the cycle
// after the input transfer, and in_tready returns after the result transfer.
// Tick: the time is added once, then per axis six coefficient reads are
// followed by the twelve Horner steps in the one shared Horner unit, and the
// axis result is sent.
// A stalled out_tready holds the result and the whole sequencer.
// Reset (rst_n low, synchronous) clears run state: id 0, status done.
// Coefficient and duration memories are not cleared and must be loaded.
module quintic_spline_trajectory_gen (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // op[2:0], segment_sel[6:3], axis_sel[9:7], coef_sel[12:10],
  // coef_value[60:13], duration_value[92:61], segment_count[97:93],
  // elapsed_time[129:98], at_goal[130], query_id[162:131]
  input  logic [167:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // axis_out[2:0], position[50:3], velocity[98:51], acceleration[146:99],
  // segment_now[150:147], traj_id[182:151]
  output logic [183:0] out_tdata,
  // status[1:0]
  output logic [1:0]   out_tuser,
  output logic         out_tlast
);
  qstg_pkg::result_t res;

  qstg_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_tvalid), .in_ready(in_tready),
    .op(in_tdata[2:0]), .seg_sel(in_tdata[6:3]), .axis_sel(in_tdata[9:7]),
    .coef_sel(in_tdata[12:10]), .coef_value(in_tdata[60:13]),
    .dur_value(in_tdata[92:61]), .seg_count(in_tdata[97:93]),
    .elapsed(in_tdata[129:98]), .at_goal(in_tdata[130]),
    .query_id(in_tdata[162:131]), .res_valid(out_tvalid),
    .res_ready(out_tready), .res(res)
  );

  assign out_tdata = {1'b0, res.id, res.seg, res.acc, res.vel, res.pos, res.axis};
  assign out_tuser = res.status;
  assign out_tlast = res.last;
endmodule

// ===== rtl/core/qstg_horner.sv =====
// One Horner step per call: acc*t truncated toward zero, saturated, plus c.
// Product is formed from two 48x16 partial products.
module qstg_horner (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic signed [qstg_pkg::DATA_W-1:0]  acc,
  input  logic signed [qstg_pkg::DATA_W-1:0]  c,
  input  logic [qstg_pkg::TIME_W-1:0]         t,
  output logic                                done,
  output logic signed [qstg_pkg::DATA_W-1:0]  res
);
  logic [1:0]  ph_r;
  logic        neg_r;
  logic [47:0] m_r;
  logic [63:0] ph_hi_r;
  logic [63:0] pl_lo_r;
  logic signed [qstg_pkg::DATA_W-1:0] c_r;
  logic [79:0] s;
  logic [79:0] sh;
  logic [47:0] lim;
  logic [47:0] r;
  logic signed [51:0] sum;

  always_comb begin
    s   = {ph_hi_r, 16'd0} + {16'd0, pl_lo_r};
    sh  = s >> qstg_pkg::TIME_FRAC_BITS;
    lim = neg_r ? 48'h800000000000 : 48'h7FFFFFFFFFFF;
    r   = (sh > {32'd0, lim}) ? lim : sh[47:0];
    sum = (neg_r ? -$signed({4'd0, r}) : $signed({4'd0, r})) +
          {{4{c_r[47]}}, c_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r <= 2'd0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      case (ph_r)
        2'd0: if (start) begin
          neg_r <= acc[47];
          m_r   <= acc[47] ? 48'(-acc) : 48'(acc);
          c_r   <= c;
          ph_r  <= 2'd1;
        end
        2'd1: begin
          ph_hi_r <= m_r * t[31:16];
          pl_lo_r <= m_r * t[15:0];
          ph_r    <= 2'd2;
        end
        2'd2: begin
          res  <= qstg_pkg::sat52(sum);
          done <= 1'b1;
          ph_r <= 2'd0;
        end
        default: ph_r <= 2'd0;
      endcase
    end
  end
endmodule

// ===== rtl/core/qstg_ctrl.sv =====
// Sequencer: coefficient memory, duration table, run state and evaluation.
module qstg_ctrl (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [2:0]                         op,
  input  logic [qstg_pkg::SEG_W-1:0]         seg_sel,
  input  logic [qstg_pkg::AXIS_W-1:0]        axis_sel,
  input  logic [qstg_pkg::POW_W-1:0]         coef_sel,
  input  logic signed [qstg_pkg::DATA_W-1:0] coef_value,
  input  logic [qstg_pkg::TIME_W-1:0]        dur_value,
  input  logic [qstg_pkg::CNT_W-1:0]         seg_count,
  input  logic [qstg_pkg::TIME_W-1:0]        elapsed,
  input  logic                               at_goal,
  input  logic [qstg_pkg::ID_W-1:0]          query_id,
  output logic                               res_valid,
  input  logic                               res_ready,
  output qstg_pkg::result_t                  res
);
  typedef enum logic [2:0] {
    S_IDLE, S_TICK, S_READ, S_LOAD, S_EVAL, S_OUT
  } state_t;

  state_t state_r;
  logic signed [qstg_pkg::DATA_W-1:0] coef_mem [qstg_pkg::COEF_DEPTH];
  logic [qstg_pkg::TIME_W-1:0] dur_mem [qstg_pkg::MAX_SEGMENTS];
  logic signed [qstg_pkg::DATA_W-1:0] rd_r;
  logic [qstg_pkg::COEF_AW-1:0] rd_addr;

  logic [qstg_pkg::CNT_W-1:0]  active_r;
  logic [qstg_pkg::SEG_W-1:0]  seg_r;
  logic [qstg_pkg::TIME_W-1:0] time_r;
  logic [qstg_pkg::ID_W-1:0]   id_r;
  logic [1:0]                  stat_r;
  logic                        goal_r;
  logic [qstg_pkg::TIME_W-1:0] el_r;

  logic [qstg_pkg::AXIS_W-1:0] axis_r;
  logic [2:0]  pw_r;      // power being read
  logic        rdv_r;     // read in flight
  logic signed [qstg_pkg::DATA_W-1:0] c_r [qstg_pkg::NPOW];
  logic [3:0]  step_r;    // Horner step 0..11
  logic        busy_r;
  logic signed [qstg_pkg::DATA_W-1:0] p_r, v_r, a_r;

  logic h_start, h_done;
  logic signed [qstg_pkg::DATA_W-1:0] h_acc, h_c, h_res;
  logic [32:0] tsum;
  logic [qstg_pkg::TIME_W-1:0] tsat, dcur;

  qstg_horner u_horner (
    .clk(clk), .rst_n(rst_n), .start(h_start), .acc(h_acc), .c(h_c),
    .t(time_r), .done(h_done), .res(h_res)
  );

  function automatic logic signed [qstg_pkg::DATA_W-1:0] kmul(
    input logic [4:0] k, input logic signed [qstg_pkg::DATA_W-1:0] x);
    logic signed [53:0] pr;
    pr = $signed({1'b0, k}) * x;
    if (pr > 54'sd140737488355327) return qstg_pkg::MAX48;
    if (pr < -54'sd140737488355328) return qstg_pkg::MIN48;
    return pr[47:0];
  endfunction

  assign rd_addr = qstg_pkg::COEF_AW'((seg_r * qstg_pkg::AXES + axis_r) * qstg_pkg::NPOW + pw_r);
  assign in_ready = (state_r == S_IDLE);
  assign tsum = {1'b0, time_r} + {1'b0, el_r};
  assign tsat = tsum[32] ? '1 : tsum[31:0];
  assign dcur = dur_mem[seg_r];

  // Horner step schedule: position 0-4, velocity 5-8, acceleration 9-11.
  always_comb begin
    h_acc = '0;
    h_c   = '0;
    case (step_r)
      4'd0:  begin h_acc = c_r[5]; h_c = c_r[4]; end
      4'd1:  begin h_acc = p_r; h_c = c_r[3]; end
      4'd2:  begin h_acc = p_r; h_c = c_r[2]; end
      4'd3:  begin h_acc = p_r; h_c = c_r[1]; end
      4'd4:  begin h_acc = p_r; h_c = c_r[0]; end
      4'd5:  begin h_acc = kmul(5'd5, c_r[5]); h_c = kmul(5'd4, c_r[4]); end
      4'd6:  begin h_acc = v_r; h_c = kmul(5'd3, c_r[3]); end
      4'd7:  begin h_acc = v_r; h_c = kmul(5'd2, c_r[2]); end
      4'd8:  begin h_acc = v_r; h_c = c_r[1]; end
      4'd9:  begin h_acc = kmul(5'd20, c_r[5]); h_c = kmul(5'd12, c_r[4]); end
      4'd10: begin h_acc = a_r; h_c = kmul(5'd6, c_r[3]); end
      4'd11: begin h_acc = a_r; h_c = kmul(5'd2, c_r[2]); end
      default: ;
    endcase
  end
  assign h_start = (state_r == S_EVAL) && !busy_r;

  // Memory writes and registered read.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready && op == qstg_pkg::OP_LOAD_COEF &&
        axis_sel < qstg_pkg::AXIS_W'(qstg_pkg::AXES) &&
        coef_sel < qstg_pkg::POW_W'(qstg_pkg::NPOW))
      coef_mem[qstg_pkg::COEF_AW'((seg_sel * qstg_pkg::AXES + axis_sel) *
               qstg_pkg::NPOW + coef_sel)] <= coef_value;
    if (in_valid && in_ready && op == qstg_pkg::OP_LOAD_DUR)
      dur_mem[seg_sel] <= dur_value;
    rd_r <= coef_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      active_r  <= 5'd1;
      seg_r     <= '0;
      time_r    <= '0;
      id_r      <= '0;
      stat_r    <= qstg_pkg::ST_DONE;
      res_valid <= 1'b0;
      busy_r    <= 1'b0;
      rdv_r     <= 1'b0;
    end else begin
      case (state_r)
        S_IDLE: if (in_valid) begin
          goal_r <= at_goal;
          el_r   <= elapsed;
          case (op)
            qstg_pkg::OP_START: begin
              active_r <= (seg_count == 0) ? 5'd1 :
                          (seg_count > qstg_pkg::CNT_W'(qstg_pkg::MAX_SEGMENTS)) ?
                          qstg_pkg::CNT_W'(qstg_pkg::MAX_SEGMENTS) : seg_count;
              seg_r  <= '0;
              time_r <= '0;
              stat_r <= qstg_pkg::ST_ACTIVE;
              id_r   <= id_r + 1'b1;
              res <= '{axis: '0, pos: '0, vel: '0, acc: '0, seg: '0,
                       id: id_r + 1'b1, status: qstg_pkg::ST_ACTIVE, last: 1'b1};
              res_valid <= 1'b1;
              state_r <= S_OUT;
            end
            qstg_pkg::OP_QUERY: begin
              res <= '{axis: '0, pos: '0, vel: '0, acc: '0, seg: seg_r, id: id_r,
                       status: (query_id == id_r) ? stat_r :
                               (query_id > id_r) ? qstg_pkg::ST_NONE : qstg_pkg::ST_DONE,
                       last: 1'b1};
              res_valid <= 1'b1;
              state_r <= S_OUT;
            end
            qstg_pkg::OP_TICK: state_r <= S_TICK;
            default: ;
          endcase
        end
        S_TICK: begin
          // Add time and advance at most one segment.
          if (tsat > dcur) begin
            if (5'(seg_r) + 5'd1 < active_r) begin
              seg_r  <= seg_r + 1'b1;
              time_r <= tsat - dcur;
            end else begin
              if (goal_r) stat_r <= qstg_pkg::ST_DONE;
              seg_r  <= 4'(active_r - 5'd1);
              time_r <= dur_mem[4'(active_r - 5'd1)];
            end
          end else begin
            time_r <= tsat;
          end
          axis_r  <= '0;
          pw_r    <= '0;
          rdv_r   <= 1'b0;
          state_r <= S_READ;
        end
        S_READ: begin
          // One coefficient per cycle; its data comes back through the registered read rd_r.
          rdv_r <= 1'b1;
          if (rdv_r) c_r[pw_r - 3'd1] <= rd_r;
          if (pw_r == 3'(qstg_pkg::NPOW)) begin
            state_r <= S_EVAL;
            step_r  <= '0;
            rdv_r   <= 1'b0;
          end else begin
            pw_r <= pw_r + 1'b1;
          end
        end
        S_EVAL: begin
          if (h_start) busy_r <= 1'b1;
          if (h_done) begin
            busy_r <= 1'b0;
            if (step_r <= 4'd4) p_r <= h_res;
            else if (step_r <= 4'd8) v_r <= h_res;
            else a_r <= h_res;
            if (step_r == 4'd11) begin
              res <= '{axis: axis_r, pos: p_r, vel: v_r, acc: h_res, seg: seg_r,
                       id: id_r, status: stat_r,
                       last: (axis_r == qstg_pkg::AXIS_W'(qstg_pkg::AXES - 1))};
              res_valid <= 1'b1;
              state_r <= S_OUT;
            end else begin
              step_r <= step_r + 1'b1;
            end
          end
        end
        S_OUT: if (res_ready) begin
          res_valid <= 1'b0;
          if (res.last || res.status == qstg_pkg::ST_NONE) begin
            state_r <= S_IDLE;
          end else if (step_r != 4'd11) begin
            state_r <= S_IDLE;
          end else begin
            axis_r  <= axis_r + 1'b1;
            pw_r    <= '0;
            step_r  <= '0;
            state_r <= S_READ;
          end
        end
        default: state_r <= S_IDLE;
      endcase
      if (state_r == S_IDLE && in_valid && (op == qstg_pkg::OP_START ||
          op == qstg_pkg::OP_QUERY)) step_r <= '0;
    end
  end
endmodule

// ===== rtl/core/qstg_checker.sv =====
module qstg_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         in_tvalid,
  input logic         in_tready,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [183:0] out_tdata,
  input logic [1:0]   out_tuser,
  input logic         out_tlast
);
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) &&
    $stable(out_tuser) && $stable(out_tlast))
    else $error("result changed while stalled");
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |-> !out_tvalid)
    else $error("input taken during output");
  a_stat: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tuser <= qstg_pkg::ST_NONE)
    else $error("bad status");
  a_none: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == qstg_pkg::ST_NONE |-> out_tlast)
    else $error("unknown-id report not marked last");
  a_rst: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("valid after reset");
endmodule

bind quintic_spline_trajectory_gen qstg_checker u_qstg_checker (.*);

// ===== sim/tb_quintic_spline_trajectory_gen.sv =====
module tb_quintic_spline_trajectory_gen;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 20000;
  // Segments that the random part loads; ticks never reach past them.
  localparam int LOADED_SEGS = 4;
  localparam logic [2:0] OP_SPARE_LO = 3'd5;
  localparam logic [2:0] OP_SPARE_HI = 3'd7;

  typedef struct packed {
    logic [2:0]  op;
    logic [3:0]  seg;
    logic [2:0]  axis;
    logic [2:0]  pw;
    logic [47:0] coef;
    logic [31:0] dur;
    logic [4:0]  count;
    logic [31:0] elapsed;
    logic        at_goal;
    logic [31:0] qid;
  } cmd_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [167:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [183:0] out_tdata;
  logic [1:0] out_tuser;
  logic out_tlast;

  quintic_spline_trajectory_gen dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast)
  );

  // Clock generation.
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Shadow copy of the trajectory state.
  logic signed [47:0] coef_mem [qstg_pkg::MAX_SEGMENTS*qstg_pkg::AXES*qstg_pkg::NPOW];
  logic [31:0] dur_mem [qstg_pkg::MAX_SEGMENTS];
  int unsigned seg_total;
  logic [3:0]  seg_cur;
  logic [31:0] seg_clock;
  logic [31:0] traj_id_cur;
  logic [1:0]  run_state;

  cmd_t cmd_q[$];
  qstg_pkg::result_t motion_q[$];
  int errors = 0;
  int n_ticks = 0, n_starts = 0, n_queries = 0, n_results = 0;
  int watchdog = 0;
  bit stim_done = 0;
  bit in_taken = 0;

  // Generator view of the trajectory: segments in use and ticks since start.
  int gen_active = 1;
  int gen_ticks = 0;

  function automatic logic signed [47:0] sat48(input logic signed [63:0] v);
    if (v > 64'sd140737488355327) return qstg_pkg::MAX48;
    if (v < -64'sd140737488355328) return qstg_pkg::MIN48;
    return v[47:0];
  endfunction

  // Product with time, shifted toward zero and saturated.
  function automatic logic signed [47:0] time_scale(input logic signed [47:0] p,
                                                    input logic [31:0] t);
    logic [47:0] m;
    logic [79:0] prod;
    logic [79:0] r;
    logic [79:0] lim;
    m = p[47] ? -p : p;
    prod = {32'd0, m} * {48'd0, t};
    r = prod >> qstg_pkg::TIME_FRAC_BITS;
    lim = p[47] ? (80'd1 << 47) : (80'd1 << 47) - 1;
    if (r > lim) r = lim;
    return p[47] ? -$signed(r[47:0]) : $signed(r[47:0]);
  endfunction

  function automatic logic signed [47:0] horner(input logic signed [47:0] acc,
                                                input logic [31:0] t,
                                                input logic signed [47:0] c);
    return sat48(64'(time_scale(acc, t)) + 64'(c));
  endfunction

  function automatic logic signed [47:0] kmul(input int k, input logic signed [47:0] c);
    return sat48(64'(k) * 64'(c));
  endfunction

  // Apply one accepted command to the shadow state and queue its results.
  task automatic predict_motion(input cmd_t c);
    qstg_pkg::result_t r;
    logic [32:0] sum;
    logic signed [47:0] cf [6];
    logic signed [47:0] p, v, a;
    int base;
    r = '0;
    case (c.op)
      qstg_pkg::OP_LOAD_COEF: begin
        if (c.axis < qstg_pkg::AXES && c.pw < qstg_pkg::NPOW)
          coef_mem[(c.seg*qstg_pkg::AXES + c.axis)*qstg_pkg::NPOW + c.pw] = c.coef;
      end
      qstg_pkg::OP_LOAD_DUR: dur_mem[c.seg] = c.dur;
      qstg_pkg::OP_START: begin
        seg_total = (c.count == 0) ? 1 :
                    (c.count > qstg_pkg::MAX_SEGMENTS) ? qstg_pkg::MAX_SEGMENTS : c.count;
        seg_cur = 0;
        seg_clock = 0;
        run_state = qstg_pkg::ST_ACTIVE;
        traj_id_cur = traj_id_cur + 1;
        r.id = traj_id_cur;
        r.status = qstg_pkg::ST_ACTIVE;
        r.last = 1'b1;
        motion_q.push_back(r);
        n_starts++;
      end
      qstg_pkg::OP_TICK: begin
        sum = {1'b0, seg_clock} + {1'b0, c.elapsed};
        seg_clock = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
        if (seg_clock > dur_mem[seg_cur]) begin
          seg_clock -= dur_mem[seg_cur];
          if (seg_cur + 1 < seg_total) seg_cur++;
          else begin
            if (c.at_goal) run_state = qstg_pkg::ST_DONE;
            seg_cur = 4'(seg_total - 1);
            seg_clock = dur_mem[seg_cur];
          end
        end
        for (int k = 0; k < qstg_pkg::AXES; k++) begin
          base = (seg_cur*qstg_pkg::AXES + k)*qstg_pkg::NPOW;
          for (int i = 0; i < 6; i++) cf[i] = coef_mem[base + i];
          p = horner(cf[5], seg_clock, cf[4]);
          p = horner(p, seg_clock, cf[3]);
          p = horner(p, seg_clock, cf[2]);
          p = horner(p, seg_clock, cf[1]);
          p = horner(p, seg_clock, cf[0]);
          v = horner(kmul(5, cf[5]), seg_clock, kmul(4, cf[4]));
          v = horner(v, seg_clock, kmul(3, cf[3]));
          v = horner(v, seg_clock, kmul(2, cf[2]));
          v = horner(v, seg_clock, cf[1]);
          a = horner(kmul(20, cf[5]), seg_clock, kmul(12, cf[4]));
          a = horner(a, seg_clock, kmul(6, cf[3]));
          a = horner(a, seg_clock, kmul(2, cf[2]));
          r.axis = 3'(k);
          r.pos = p;
          r.vel = v;
          r.acc = a;
          r.seg = seg_cur;
          r.id = traj_id_cur;
          r.status = run_state;
          r.last = (k == qstg_pkg::AXES-1);
          motion_q.push_back(r);
        end
        n_ticks++;
      end
      qstg_pkg::OP_QUERY: begin
        r.seg = seg_cur;
        r.id = traj_id_cur;
        r.status = (c.qid == traj_id_cur) ? run_state :
                   (c.qid > traj_id_cur) ? qstg_pkg::ST_NONE : qstg_pkg::ST_DONE;
        r.last = 1'b1;
        motion_q.push_back(r);
        n_queries++;
      end
      default: ;
    endcase
  endtask

  function automatic logic [167:0] pack_cmd(input cmd_t c);
    return {5'd0, c.qid, c.at_goal, c.elapsed, c.count, c.dur, c.coef,
            c.pw, c.axis, c.seg, c.op};
  endfunction

  function automatic cmd_t blank_cmd(input logic [2:0] op);
    cmd_t c;
    c = '0;
    c.op = op;
    return c;
  endfunction

  // Input side: every accepted transfer goes to the predictor at the clock edge.
  always @(posedge clk) begin
    in_taken = rst_n && in_tvalid && in_tready;
    if (in_taken) predict_motion(cmd_q.pop_front());
  end

  // Driver: bursts of transfers with random gaps, fed from the command queue.
  int burst_left = 0;
  int gap_left = 0;
  bit hold_for_drain = 0;
  always @(negedge clk) begin
    if (rst_n) begin
      if (in_tvalid && !in_taken) begin
        // Hold the current transfer until it is accepted.
      end else if (cmd_q.size() == 0 || (hold_for_drain && motion_q.size() != 0)) begin
        in_tvalid <= 1'b0;
      end else if (gap_left > 0) begin
        gap_left--;
        in_tvalid <= 1'b0;
      end else begin
        in_tvalid <= 1'b1;
        in_tdata <= pack_cmd(cmd_q[0]);
        if (burst_left > 0) burst_left--;
        else begin
          burst_left = $urandom_range(0, 12);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
        end
      end
    end
  end

  // Receiver stall pattern: periodic, with random stalls in part of each period.
  int stall_phase = 0;
  always @(negedge clk) begin
    stall_phase = (stall_phase + 1) % 64;
    if (stall_phase < 24) out_tready <= 1'b1;
    else out_tready <= ($urandom_range(0, 3) != 0);
  end

  // Monitor: compare each result transfer with the oldest expectation.
  always @(posedge clk) begin
    qstg_pkg::result_t got, want;
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) watchdog <= 0;
      else watchdog <= watchdog + 1;
      if (out_tvalid && out_tready) begin
        n_results++;
        got.axis = out_tdata[2:0];
        got.pos = out_tdata[50:3];
        got.vel = out_tdata[98:51];
        got.acc = out_tdata[146:99];
        got.seg = out_tdata[150:147];
        got.id = out_tdata[182:151];
        got.status = out_tuser;
        got.last = out_tlast;
        if (motion_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected result %h", $time, got);
        end else begin
          want = motion_q.pop_front();
          if (got.axis != want.axis || got.pos != want.pos || got.vel != want.vel ||
              got.acc != want.acc || got.seg != want.seg || got.id != want.id ||
              got.status != want.status || got.last != want.last) begin
            errors++;
            $display({"%0t: mismatch expected axis=%0d pos=%h vel=%h acc=%h",
                      " seg=%0d id=%0d st=%0d last=%0b"},
                     $time, want.axis, want.pos, want.vel, want.acc, want.seg,
                     want.id, want.status, want.last);
            $display({"%0t:          actual   axis=%0d pos=%h vel=%h acc=%h",
                      " seg=%0d id=%0d st=%0d last=%0b"},
                     $time, got.axis, got.pos, got.vel, got.acc, got.seg,
                     got.id, got.status, got.last);
          end
        end
      end
      if (watchdog >= WATCHDOG_LIMIT) begin
        $display("Watchdog expired with %0d results outstanding", motion_q.size());
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  function automatic logic [47:0] rand48();
    case ($urandom_range(0, 5))
      0: return qstg_pkg::MAX48;
      1: return qstg_pkg::MIN48;
      2: return 48'($signed($urandom_range(0, 2000)) - 1000) << 24;
      3: return 48'({$urandom, $urandom});
      default: return 48'($signed($urandom_range(0, 65535)) - 32768) << $urandom_range(8, 28);
    endcase
  endfunction

  // Fill the first segments completely so no tick reads an unwritten entry.
  task automatic queue_table_load(input bit extreme, input int nseg);
    cmd_t c;
    for (int s = 0; s < nseg; s++) begin
      c = blank_cmd(qstg_pkg::OP_LOAD_DUR);
      c.seg = 4'(s);
      c.dur = extreme ? ((s % 2) ? 32'hFFFF_FFFF : 32'd0) : $urandom_range(1 << 18, 3 << 20);
      cmd_q.push_back(c);
      for (int ax = 0; ax < qstg_pkg::AXES; ax++)
        for (int pw = 0; pw < qstg_pkg::NPOW; pw++) begin
          c = blank_cmd(qstg_pkg::OP_LOAD_COEF);
          c.seg = 4'(s);
          c.axis = 3'(ax);
          c.pw = 3'(pw);
          c.coef = extreme ? ((pw % 2) ? qstg_pkg::MAX48 : qstg_pkg::MIN48) : rand48();
          cmd_q.push_back(c);
        end
    end
  endtask

  // Queue a start and note how far its trajectory may advance.
  task automatic queue_start(input logic [4:0] count);
    cmd_t c;
    c = blank_cmd(qstg_pkg::OP_START);
    c.count = count;
    cmd_q.push_back(c);
    gen_active = (count == 0) ? 1 :
                 (count > qstg_pkg::MAX_SEGMENTS) ? qstg_pkg::MAX_SEGMENTS : int'(count);
    gen_ticks = 0;
  endtask

  task automatic queue_tick(input cmd_t c);
    cmd_q.push_back(c);
    gen_ticks++;
  endtask

  // A tick advances at most one segment, so it stays inside the loaded ones.
  function automatic bit tick_allowed();
    return (gen_active <= LOADED_SEGS) || (gen_ticks + 1 < LOADED_SEGS);
  endfunction

  function automatic cmd_t rand_tick();
    cmd_t c;
    c = blank_cmd(qstg_pkg::OP_TICK);
    c.elapsed = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 1 << 20);
    c.at_goal = $urandom_range(0, 1);
    c.qid = $urandom;
    return c;
  endfunction

  initial begin
    cmd_t c;
    int n;
    for (int i = 0; i < qstg_pkg::MAX_SEGMENTS*qstg_pkg::AXES*qstg_pkg::NPOW; i++)
      coef_mem[i] = '0;
    for (int i = 0; i < qstg_pkg::MAX_SEGMENTS; i++) dur_mem[i] = '0;
    seg_total = 1;
    seg_cur = 0;
    seg_clock = 0;
    traj_id_cur = 0;
    run_state = qstg_pkg::ST_DONE;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part: queries around the reset id, extreme values in the first
    // two segments, then starts and ticks that never leave those segments.
    c = blank_cmd(qstg_pkg::OP_QUERY); c.qid = 0; cmd_q.push_back(c);
    c = blank_cmd(qstg_pkg::OP_QUERY); c.qid = 32'hFFFF_FFFF; cmd_q.push_back(c);
    queue_table_load(1, 2);
    c = blank_cmd(OP_SPARE_LO); cmd_q.push_back(c);
    c = blank_cmd(OP_SPARE_HI); c = ~c; c.op = OP_SPARE_HI; cmd_q.push_back(c);
    c = blank_cmd(qstg_pkg::OP_LOAD_COEF);
    c.axis = 3'd7; c.pw = 3'd6; c.coef = '1; cmd_q.push_back(c);
    queue_start(5'd0);
    c = blank_cmd(qstg_pkg::OP_TICK); c.elapsed = 32'hFFFF_FFFF; c.at_goal = 0; queue_tick(c);
    c = blank_cmd(qstg_pkg::OP_TICK); c.elapsed = 32'hFFFF_FFFF; c.at_goal = 1; queue_tick(c);
    c = blank_cmd(qstg_pkg::OP_QUERY); c.qid = 1; cmd_q.push_back(c);
    queue_start(5'd31);
    c = blank_cmd(qstg_pkg::OP_TICK); c.elapsed = 1; queue_tick(c);
    c = blank_cmd(qstg_pkg::OP_TICK); c.elapsed = 0; queue_tick(c);
    c = blank_cmd(qstg_pkg::OP_QUERY); c.qid = 0; cmd_q.push_back(c);
    queue_start(5'd16);
    for (int i = 0; i < 4; i++) begin
      c = blank_cmd(qstg_pkg::OP_TICK); c.elapsed = 32'hFFFF_FFFF; c.at_goal = i[0];
      queue_tick(c);
    end

    // Wait for the directed part to drain, holding the sender once.
    hold_for_drain = 1;
    wait (cmd_q.size() == 0 && motion_q.size() == 0);
    hold_for_drain = 0;

    // Random part: reload with moderate values, then trajectories with random content.
    queue_table_load(0, LOADED_SEGS);
    n = 0;
    while (n < 200) begin
      case ($urandom_range(0, 9))
        0: begin
          queue_start(5'($urandom_range(0, 31)));
          n++;
          repeat ($urandom_range(2, 12)) begin
            if (tick_allowed()) begin
              queue_tick(rand_tick());
              n++;
            end
          end
        end
        1: begin
          c = blank_cmd(qstg_pkg::OP_QUERY);
          case ($urandom_range(0, 3))
            0: c.qid = traj_id_cur + n_starts;
            1: c.qid = $urandom_range(0, 40);
            default: c.qid = $urandom;
          endcase
          cmd_q.push_back(c);
          n++;
        end
        2: begin
          c = rand_tick();
          c.op = ($urandom_range(0, 2) == 0) ? qstg_pkg::OP_LOAD_DUR : qstg_pkg::OP_LOAD_COEF;
          c.seg = $urandom_range(0, 15);
          c.axis = $urandom_range(0, 7);
          c.pw = $urandom_range(0, 7);
          c.coef = rand48();
          c.dur = ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(1, 4 << 20);
          c.count = $urandom_range(0, 31);
          cmd_q.push_back(c);
          n++;
        end
        3: begin
          c = rand_tick();
          c.op = 3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
          cmd_q.push_back(c);
        end
        default: begin
          if (tick_allowed()) queue_tick(rand_tick());
          else queue_start(5'($urandom_range(0, 31)));
          n++;
        end
      endcase
      if (cmd_q.size() > 64) wait (cmd_q.size() < 16);
    end
    stim_done = 1;
  end

  // End of run: wait for the queues to drain, then allow a tick's latency.
  initial begin
    wait (stim_done && cmd_q.size() == 0 && !in_tvalid && motion_q.size() == 0);
    repeat (400) @(posedge clk);
    $display("Covered %0d starts, %0d ticks and %0d queries; %0d result transfers checked.",
             n_starts, n_ticks, n_queries, n_results);
    if (errors == 0 && motion_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
